// File: rtl/core/imrmv_pkg.sv
// Shared types, register map and helpers for the IMU running mean/variance block.
package imrmv_pkg;

   localparam int DATA_W = 64;
   localparam int ITER_W = 7;

   typedef enum logic [1:0] {
      ALU_MUL,
      ALU_DIV,
      ALU_SQRT
   } alu_op_type;

   typedef struct packed {
      logic              start;
      alu_op_type        op;
      logic [ITER_W-1:0] iters;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
   } alu_cmd_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [DATA_W-1:0] hi;
      logic [DATA_W-1:0] lo;
   } alu_sts_type;

   localparam logic [1:0] REG_NORMALIZE = 2'd0;
   localparam logic [1:0] REG_GMAG      = 2'd1;
   localparam logic [1:0] REG_ASCALE    = 2'd2;
   localparam logic [1:0] REG_GSCALE    = 2'd3;

   localparam logic [23:0] GMAG_RESET  = 24'd642908;
   localparam logic [15:0] SCALE_RESET = 16'd256;

   function automatic logic [31:0] sat32(input logic signed [63:0] v);
      logic [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// File: rtl/core/imrmv_if.sv
// Request and response channel interfaces for the IMU running mean/variance block.
interface imrmv_req_if;
   logic               valid;
   logic               ready;
   logic               start_over;
   logic signed [31:0] accel_x;
   logic signed [31:0] accel_y;
   logic signed [31:0] accel_z;
   logic signed [31:0] gyro_x;
   logic signed [31:0] gyro_y;
   logic signed [31:0] gyro_z;

   modport source (output valid, start_over, accel_x, accel_y, accel_z,
                   gyro_x, gyro_y, gyro_z, input ready);
   modport sink   (input valid, start_over, accel_x, accel_y, accel_z,
                   gyro_x, gyro_y, gyro_z, output ready);
endinterface

interface imrmv_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] gravity_x;
   logic signed [31:0] gravity_y;
   logic signed [31:0] gravity_z;
   logic signed [31:0] gyro_bias_x;
   logic signed [31:0] gyro_bias_y;
   logic signed [31:0] gyro_bias_z;
   logic [31:0]        accel_var_x;
   logic [31:0]        accel_var_y;
   logic [31:0]        accel_var_z;
   logic [31:0]        gyro_var_x;
   logic [31:0]        gyro_var_y;
   logic [31:0]        gyro_var_z;

   modport source (output valid, gravity_x, gravity_y, gravity_z, gyro_bias_x,
                   gyro_bias_y, gyro_bias_z, accel_var_x, accel_var_y, accel_var_z,
                   gyro_var_x, gyro_var_y, gyro_var_z, input ready);
   modport sink   (input valid, gravity_x, gravity_y, gravity_z, gyro_bias_x,
                   gyro_bias_y, gyro_bias_z, accel_var_x, accel_var_y, accel_var_z,
                   gyro_var_x, gyro_var_y, gyro_var_z, output ready);
endinterface

// File: rtl/core/imrmv_alu.sv
// Bit-serial multiply, divide and square-root unit shared by the sequencer.
module imrmv_alu (
   input  logic                  clock,
   input  logic                  reset,
   input  imrmv_pkg::alu_cmd_type cmd,
   output imrmv_pkg::alu_sts_type sts
);

   logic [63:0] hi_ff, hi_in;
   logic [63:0] lo_ff, lo_in;
   logic [63:0] aux_ff, aux_in;
   logic [imrmv_pkg::ITER_W-1:0] cnt_ff, cnt_in;
   logic done_ff, done_in;
   imrmv_pkg::alu_op_type op_ff, op_in;

   logic [64:0] mul_sum;
   logic [32:0] div_rs;
   logic        div_ge;
   logic [63:0] sq_t;
   logic        sq_ge;

   always_comb begin
      mul_sum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, aux_ff} : 65'd0);
      div_rs  = {hi_ff[31:0], lo_ff[63]};
      div_ge  = div_rs >= {1'b0, aux_ff[31:0]};
      sq_t    = lo_ff + aux_ff;
      sq_ge   = hi_ff >= sq_t;

      hi_in   = hi_ff;
      lo_in   = lo_ff;
      aux_in  = aux_ff;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      done_in = 1'b0;

      if (cmd.start) begin
         cnt_in = cmd.iters;
         op_in  = cmd.op;
         case (cmd.op)
            imrmv_pkg::ALU_MUL: begin
               hi_in  = '0;
               lo_in  = cmd.b;
               aux_in = cmd.a;
            end
            imrmv_pkg::ALU_DIV: begin
               hi_in  = '0;
               lo_in  = cmd.a;
               aux_in = cmd.b;
            end
            imrmv_pkg::ALU_SQRT: begin
               hi_in  = cmd.a;
               lo_in  = '0;
               aux_in = 64'h4000_0000_0000_0000;
            end
            default: begin
               hi_in = '0;
            end
         endcase
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == imrmv_pkg::ITER_W'(1));
         case (op_ff)
            imrmv_pkg::ALU_MUL: begin
               hi_in = mul_sum[64:1];
               lo_in = {mul_sum[0], lo_ff[63:1]};
            end
            imrmv_pkg::ALU_DIV: begin
               hi_in = {31'd0, div_ge ? div_rs - {1'b0, aux_ff[31:0]} : div_rs};
               lo_in = {lo_ff[62:0], div_ge};
            end
            imrmv_pkg::ALU_SQRT: begin
               hi_in  = sq_ge ? hi_ff - sq_t : hi_ff;
               lo_in  = sq_ge ? (lo_ff >> 1) + aux_ff : lo_ff >> 1;
               aux_in = aux_ff >> 2;
            end
            default: begin
               hi_in = hi_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
         op_ff   <= imrmv_pkg::ALU_MUL;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
         op_ff   <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      aux_ff <= aux_in;
   end

   assign sts.busy = (cnt_ff != '0);
   assign sts.done = done_ff;
   assign sts.hi   = hi_ff;
   assign sts.lo   = lo_ff;

endmodule

// File: rtl/core/imu_running_mean_variance.sv
// Top level: IMU running mean/variance estimator with sequencer, CSRs and result register.
//
//   channel  dir  handshake            carries
//   req_bus  in   valid/ready          start_over, 3 accel + 3 gyro samples (Q16.16)
//   rsp_bus  out  valid/ready          gravity, gyro bias, scaled variances
//   csr_*    in   APB psel/penable     normalize, gravity magnitude, variance scales
//
// Each sample runs six axis updates plus, with normalization on, the gravity pass,
// all through one bit-serial multiply/divide/sqrt unit that resolves one bit per cycle.
// Reset is synchronous; it resets the sequencer, sample count, CSRs and result valid flag.
// req_bus.ready is high only while idle; a finished result waits in the output
// register, and the next sample may be taken while it waits.
module imu_running_mean_variance #(
   parameter longint unsigned MAX_COUNT    = 65535,
   parameter int              SAMPLE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   imrmv_req_if.sink   req_bus,
   imrmv_rsp_if.source rsp_bus,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int SW  = SAMPLE_WIDTH;
   localparam int CW  = $clog2(MAX_COUNT + 1);
   localparam int GW  = (SW > 31) ? SW : 31;
   localparam int MK  = SW + 1;
   localparam int SQK = (SW + 1 > 40) ? 40 : SW + 1;
   localparam int VK  = 32 + CW;

   typedef enum logic [15:0] {
      S_IDLE  = 16'h0001,
      S_MEAN  = 16'h0002,
      S_SQR   = 16'h0004,
      S_TDIV  = 16'h0008,
      S_TMUL  = 16'h0010,
      S_TDIV2 = 16'h0020,
      S_VMUL  = 16'h0040,
      S_VDIV  = 16'h0080,
      S_SCALE = 16'h0100,
      S_GABS  = 16'h0200,
      S_GNORM = 16'h0400,
      S_GSQ   = 16'h0800,
      S_GSQRT = 16'h1000,
      S_GMUL  = 16'h2000,
      S_GDIV  = 16'h4000,
      S_DONE  = 16'h8000
   } state_type;

   state_type state_ff, state_in;
   logic      issue_ff, issue_in;
   logic [2:0] axis_ff, axis_in;
   logic [CW-1:0] n_ff, n_in;
   logic      first_ff, first_in;

   logic        norm_ff, norm_in;
   logic [23:0] gmag_ff, gmag_in;
   logic [15:0] ascale_ff, ascale_in;
   logic [15:0] gscale_ff, gscale_in;

   logic signed [SW-1:0] x_ff [6];
   logic signed [SW-1:0] x_in [6];
   logic signed [SW-1:0] mean_ff [6];
   logic signed [SW-1:0] mean_in [6];
   logic [31:0] var_ff [6];
   logic [31:0] var_in [6];
   logic [31:0] svar_ff [6];
   logic [31:0] svar_in [6];
   logic [63:0] t_ff, t_in;
   logic [63:0] w_ff, w_in;
   logic [GW-1:0] ga_ff [3];
   logic [GW-1:0] ga_in [3];
   logic [63:0] sum_ff, sum_in;
   logic [31:0] r_ff, r_in;
   logic [54:0] gmul_ff, gmul_in;
   logic [31:0] grav_ff [3];
   logic [31:0] grav_in [3];

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] out_grav_ff [3];
   logic [31:0] out_grav_in [3];
   logic [31:0] out_bias_ff [3];
   logic [31:0] out_bias_in [3];
   logic [31:0] out_avar_ff [3];
   logic [31:0] out_avar_in [3];
   logic [31:0] out_gvar_ff [3];
   logic [31:0] out_gvar_in [3];

   imrmv_pkg::alu_cmd_type alu_cmd;
   imrmv_pkg::alu_sts_type alu_sts;

   logic              req_beat;
   logic              csr_write;
   logic [31:0]       raw [6];
   logic [63:0]       raw64;
   logic signed [SW-1:0] x_sel, m_sel;
   logic signed [SW:0] d;
   logic [SW:0]       dmag;
   logic [SW:0]       q_mean;
   logic signed [SW:0] m_new;
   logic [63:0]       mag64;
   logic              sq_sat;
   logic [127:0]      prod;
   logic [CW-1:0]     nm1;
   logic [64:0]       var_sum;
   logic [31:0]       keep;
   logic [39:0]       scaled;
   logic [GW-1:0]     mx;
   logic [GW-1:0]     ga_abs [3];
   logic signed [SW:0] m_ext;
   logic              all_zero;
   logic [23:0]       gq;
   logic [2:0]        gi;

   imrmv_alu u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (alu_cmd),
      .sts   (alu_sts)
   );

   assign req_beat  = req_bus.valid && req_bus.ready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign req_bus.ready = (state_ff == S_IDLE);

   assign raw[0] = req_bus.accel_x;
   assign raw[1] = req_bus.accel_y;
   assign raw[2] = req_bus.accel_z;
   assign raw[3] = req_bus.gyro_x;
   assign raw[4] = req_bus.gyro_y;
   assign raw[5] = req_bus.gyro_z;

   always_comb begin
      gi = {1'b0, axis_ff[1:0]};
      x_sel  = x_ff[axis_ff];
      m_sel  = mean_ff[axis_ff];
      d      = {x_sel[SW-1], x_sel} - {m_sel[SW-1], m_sel};
      dmag   = d[SW] ? -d : d;
      q_mean = alu_sts.lo[SW:0];
      m_new  = d[SW] ? {m_sel[SW-1], m_sel} - q_mean : {m_sel[SW-1], m_sel} + q_mean;
      mag64  = 64'(dmag);
      sq_sat = (mag64[63:40] != 24'd0);
      prod   = {alu_sts.hi, alu_sts.lo};
      nm1    = n_ff - 1'b1;
      keep   = alu_sts.lo[31:0];
      var_sum = {1'b0, t_ff} + 65'(keep);
      scaled = 40'(prod >> 56);
      gq     = alu_sts.lo[23:0];
      for (int i = 0; i < 3; i++) begin
         m_ext     = {mean_ff[i][SW-1], mean_ff[i]};
         ga_abs[i] = GW'(m_ext[SW] ? -m_ext : m_ext);
      end
      all_zero = (ga_abs[0] == '0) && (ga_abs[1] == '0) && (ga_abs[2] == '0);
      mx = (ga_ff[0] >= ga_ff[1]) ? ga_ff[0] : ga_ff[1];
      mx = (mx >= ga_ff[2]) ? mx : ga_ff[2];
   end

   always_comb begin
      state_in = state_ff;
      issue_in = issue_ff;
      axis_in  = axis_ff;
      n_in     = n_ff;
      first_in = first_ff;
      norm_in   = norm_ff;
      gmag_in   = gmag_ff;
      ascale_in = ascale_ff;
      gscale_in = gscale_ff;
      x_in    = x_ff;
      mean_in = mean_ff;
      var_in  = var_ff;
      svar_in = svar_ff;
      t_in    = t_ff;
      w_in    = w_ff;
      ga_in   = ga_ff;
      sum_in  = sum_ff;
      r_in    = r_ff;
      gmul_in = gmul_ff;
      grav_in = grav_ff;
      rsp_valid_in = rsp_valid_ff;
      out_grav_in  = out_grav_ff;
      out_bias_in  = out_bias_ff;
      out_avar_in  = out_avar_ff;
      out_gvar_in  = out_gvar_ff;

      alu_cmd.start = 1'b0;
      alu_cmd.op    = imrmv_pkg::ALU_MUL;
      alu_cmd.iters = '0;
      alu_cmd.a     = '0;
      alu_cmd.b     = '0;

      if (csr_write) begin
         case (csr_paddr[3:2])
            imrmv_pkg::REG_NORMALIZE: norm_in   = csr_pwdata[0];
            imrmv_pkg::REG_GMAG:      gmag_in   = csr_pwdata[23:0];
            imrmv_pkg::REG_ASCALE:    ascale_in = csr_pwdata[15:0];
            imrmv_pkg::REG_GSCALE:    gscale_in = csr_pwdata[15:0];
            default:                  norm_in   = norm_ff;
         endcase
      end

      if (rsp_bus.valid && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               for (int i = 0; i < 6; i++) begin
                  raw64 = {32'd0, raw[i]};
                  x_in[i] = raw64[SW-1:0];
                  if (req_bus.start_over || first_ff) begin
                     mean_in[i] = raw64[SW-1:0];
                     var_in[i]  = '0;
                  end
               end
               if (req_bus.start_over || first_ff) begin
                  n_in     = CW'(1);
                  first_in = 1'b0;
               end
               axis_in  = '0;
               state_in = S_MEAN;
            end
         end
         S_MEAN: begin
            alu_cmd.op    = imrmv_pkg::ALU_DIV;
            alu_cmd.iters = imrmv_pkg::ITER_W'(MK);
            alu_cmd.a     = mag64 << (64 - MK);
            alu_cmd.b     = 64'(n_ff);
            if (alu_sts.done) begin
               mean_in[axis_ff] = m_new[SW-1:0];
               state_in = S_SQR;
            end
         end
         S_SQR: begin
            alu_cmd.op    = imrmv_pkg::ALU_MUL;
            alu_cmd.iters = imrmv_pkg::ITER_W'(SQK);
            alu_cmd.a     = mag64;
            alu_cmd.b     = mag64;
            if (sq_sat && !issue_ff) begin
               // deviation too large to square: pin it
               t_in     = '1;
               state_in = S_TDIV;
            end else if (alu_sts.done) begin
               t_in     = 64'(prod >> (80 - SQK));
               state_in = S_TDIV;
            end
         end
         S_TDIV: begin
            alu_cmd.op    = imrmv_pkg::ALU_DIV;
            alu_cmd.iters = imrmv_pkg::ITER_W'(64);
            alu_cmd.a     = t_ff;
            alu_cmd.b     = 64'(n_ff);
            if (alu_sts.done) begin
               t_in     = alu_sts.lo;
               state_in = S_TMUL;
            end
         end
         S_TMUL: begin
            alu_cmd.op    = imrmv_pkg::ALU_MUL;
            alu_cmd.iters = imrmv_pkg::ITER_W'(CW);
            alu_cmd.a     = t_ff;
            alu_cmd.b     = 64'(nm1);
            if (alu_sts.done) begin
               t_in     = 64'(prod >> (64 - CW));
               state_in = S_TDIV2;
            end
         end
         S_TDIV2: begin
            alu_cmd.op    = imrmv_pkg::ALU_DIV;
            alu_cmd.iters = imrmv_pkg::ITER_W'(64);
            alu_cmd.a     = t_ff;
            alu_cmd.b     = 64'(n_ff);
            if (alu_sts.done) begin
               t_in     = alu_sts.lo;
               state_in = S_VMUL;
            end
         end
         S_VMUL: begin
            alu_cmd.op    = imrmv_pkg::ALU_MUL;
            alu_cmd.iters = imrmv_pkg::ITER_W'(CW);
            alu_cmd.a     = 64'(var_ff[axis_ff]);
            alu_cmd.b     = 64'(nm1);
            if (alu_sts.done) begin
               // left-align the numerator for the divide
               w_in     = 64'(prod >> (64 - CW)) << (64 - VK);
               state_in = S_VDIV;
            end
         end
         S_VDIV: begin
            alu_cmd.op    = imrmv_pkg::ALU_DIV;
            alu_cmd.iters = imrmv_pkg::ITER_W'(VK);
            alu_cmd.a     = w_ff;
            alu_cmd.b     = 64'(n_ff);
            if (alu_sts.done) begin
               var_in[axis_ff] = (var_sum[64:32] != 33'd0) ? 32'hFFFF_FFFF : var_sum[31:0];
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            alu_cmd.op    = imrmv_pkg::ALU_MUL;
            alu_cmd.iters = imrmv_pkg::ITER_W'(16);
            alu_cmd.a     = 64'(var_ff[axis_ff]);
            alu_cmd.b     = (axis_ff < 3'd3) ? 64'(ascale_ff) : 64'(gscale_ff);
            if (alu_sts.done) begin
               svar_in[axis_ff] = (scaled[39:32] != 8'd0) ? 32'hFFFF_FFFF : scaled[31:0];
               if (axis_ff == 3'd5) begin
                  axis_in  = '0;
                  state_in = S_GABS;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = S_MEAN;
               end
            end
         end
         S_GABS: begin
            if (n_ff < CW'(MAX_COUNT)) begin
               n_in = n_ff + 1'b1;
            end
            ga_in = ga_abs;
            for (int i = 0; i < 3; i++) begin
               grav_in[i] = norm_ff ? 32'd0 : imrmv_pkg::sat32(-64'(mean_ff[i]));
            end
            state_in = (norm_ff && !all_zero) ? S_GNORM : S_DONE;
         end
         S_GNORM: begin
            if ((64'(mx) >> 31) != 64'd0) begin
               for (int i = 0; i < 3; i++) ga_in[i] = ga_ff[i] >> 1;
            end else if (!mx[30]) begin
               for (int i = 0; i < 3; i++) ga_in[i] = ga_ff[i] << 1;
            end else begin
               sum_in   = '0;
               axis_in  = '0;
               state_in = S_GSQ;
            end
         end
         S_GSQ: begin
            alu_cmd.op    = imrmv_pkg::ALU_MUL;
            alu_cmd.iters = imrmv_pkg::ITER_W'(31);
            alu_cmd.a     = 64'(ga_ff[gi[1:0]]);
            alu_cmd.b     = 64'(ga_ff[gi[1:0]]);
            if (alu_sts.done) begin
               sum_in = sum_ff + 64'(62'(prod >> 33));
               if (axis_ff == 3'd2) begin
                  axis_in  = '0;
                  state_in = S_GSQRT;
               end else begin
                  axis_in  = axis_ff + 1'b1;
               end
            end
         end
         S_GSQRT: begin
            alu_cmd.op    = imrmv_pkg::ALU_SQRT;
            alu_cmd.iters = imrmv_pkg::ITER_W'(32);
            alu_cmd.a     = sum_ff;
            if (alu_sts.done) begin
               r_in     = alu_sts.lo[31:0];
               state_in = S_GMUL;
            end
         end
         S_GMUL: begin
            alu_cmd.op    = imrmv_pkg::ALU_MUL;
            alu_cmd.iters = imrmv_pkg::ITER_W'(24);
            alu_cmd.a     = 64'(ga_ff[gi[1:0]][30:0]);
            alu_cmd.b     = 64'(gmag_ff);
            if (alu_sts.done) begin
               gmul_in  = 55'(prod >> 40);
               state_in = S_GDIV;
            end
         end
         S_GDIV: begin
            alu_cmd.op    = imrmv_pkg::ALU_DIV;
            alu_cmd.iters = imrmv_pkg::ITER_W'(55);
            alu_cmd.a     = {gmul_ff, 9'd0};
            alu_cmd.b     = 64'(r_ff);
            if (alu_sts.done) begin
               // point opposite the mean
               grav_in[gi[1:0]] = mean_ff[axis_ff][SW-1] ? 32'(gq) : -32'(gq);
               if (axis_ff == 3'd2) begin
                  state_in = S_DONE;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = S_GMUL;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               for (int i = 0; i < 3; i++) begin
                  out_grav_in[i] = grav_ff[i];
                  out_bias_in[i] = imrmv_pkg::sat32(64'(mean_ff[3 + i]));
                  out_avar_in[i] = svar_ff[i];
                  out_gvar_in[i] = svar_ff[3 + i];
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // launch one op per axis step in each state (none for a pinned square); advance on done
      if (!(state_ff == S_IDLE || state_ff == S_GABS || state_ff == S_GNORM ||
            state_ff == S_DONE) && !issue_ff && !(state_ff == S_SQR && sq_sat)) begin
         alu_cmd.start = 1'b1;
         issue_in      = 1'b1;
      end else if (alu_sts.done) begin
         issue_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issue_ff     <= 1'b0;
         axis_ff      <= '0;
         n_ff         <= CW'(1);
         first_ff     <= 1'b1;
         norm_ff      <= 1'b0;
         gmag_ff      <= imrmv_pkg::GMAG_RESET;
         ascale_ff    <= imrmv_pkg::SCALE_RESET;
         gscale_ff    <= imrmv_pkg::SCALE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         axis_ff      <= axis_in;
         n_ff         <= n_in;
         first_ff     <= first_in;
         norm_ff      <= norm_in;
         gmag_ff      <= gmag_in;
         ascale_ff    <= ascale_in;
         gscale_ff    <= gscale_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      mean_ff     <= mean_in;
      var_ff      <= var_in;
      svar_ff     <= svar_in;
      t_ff        <= t_in;
      w_ff        <= w_in;
      ga_ff       <= ga_in;
      sum_ff      <= sum_in;
      r_ff        <= r_in;
      gmul_ff     <= gmul_in;
      grav_ff     <= grav_in;
      out_grav_ff <= out_grav_in;
      out_bias_ff <= out_bias_in;
      out_avar_ff <= out_avar_in;
      out_gvar_ff <= out_gvar_in;
   end

   always_comb begin
      case (csr_paddr[3:2])
         imrmv_pkg::REG_NORMALIZE: csr_prdata = {31'd0, norm_ff};
         imrmv_pkg::REG_GMAG:      csr_prdata = {8'd0, gmag_ff};
         imrmv_pkg::REG_ASCALE:    csr_prdata = {16'd0, ascale_ff};
         imrmv_pkg::REG_GSCALE:    csr_prdata = {16'd0, gscale_ff};
         default:                  csr_prdata = '0;
      endcase
   end
   assign csr_pready = 1'b1;

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.gravity_x   = out_grav_ff[0];
   assign rsp_bus.gravity_y   = out_grav_ff[1];
   assign rsp_bus.gravity_z   = out_grav_ff[2];
   assign rsp_bus.gyro_bias_x = out_bias_ff[0];
   assign rsp_bus.gyro_bias_y = out_bias_ff[1];
   assign rsp_bus.gyro_bias_z = out_bias_ff[2];
   assign rsp_bus.accel_var_x = out_avar_ff[0];
   assign rsp_bus.accel_var_y = out_avar_ff[1];
   assign rsp_bus.accel_var_z = out_avar_ff[2];
   assign rsp_bus.gyro_var_x  = out_gvar_ff[0];
   assign rsp_bus.gyro_var_y  = out_gvar_ff[1];
   assign rsp_bus.gyro_var_z  = out_gvar_ff[2];

   a_alu_start_idle: assert property (@(posedge clock) disable iff (reset)
      alu_cmd.start |-> !alu_sts.busy)
      else $error("serial unit restarted while busy");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      n_ff != '0)
      else $error("sample count reached zero");

   a_root_range: assert property (@(posedge clock) disable iff (reset)
      (alu_cmd.start && state_ff == S_GDIV) |-> (r_ff[31:30] != 2'b00))
      else $error("gravity norm below normalized range");

   a_beat_starts: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> (state_ff == S_MEAN && axis_ff == 3'd0))
      else $error("sample beat did not start the axis pass");

   a_done_follows_busy: assert property (@(posedge clock) disable iff (reset)
      alu_sts.done |-> $past(alu_sts.busy))
      else $error("serial unit done without work");

endmodule
